>>> src/eds_pkg.sv
`timescale 1ns / 1ps

package eds_pkg;

  // widest pattern the state word can track
  localparam int unsigned PatternMaxDef = 32;
  localparam int unsigned StateWMax     = 32;

  // configuration register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned LenW     = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_LO     = 3'd0,
    CFG_PAT_MID_LO = 3'd1,
    CFG_PAT_MID_HI = 3'd2,
    CFG_PAT_HI     = 3'd3,
    CFG_PAT_LEN    = 3'd4
  } cfg_idx_e;

  localparam int unsigned CharsPerWord = CfgDataW / 8;

  // item kinds carried on the input tuser
  localparam int unsigned ModeW = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_SYMBOL    = 2'd0,
    MODE_SEG_START = 2'd1,
    MODE_ELEM_START = 2'd2,
    MODE_ELEM_END  = 2'd3
  } mode_e;

  localparam int unsigned SymW   = 8;
  localparam int unsigned CountW = 32;

  localparam logic [CountW-1:0] CountMax = '1;

  // result item as held in the output and skid registers
  typedef struct packed {
    logic [CountW-1:0] match_count;
    logic              hit;
  } result_t;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

endpackage

>>> src/eds_shift_and_matcher_top.sv
`timescale 1ns / 1ps

// Shift-And matcher for elastic degenerate strings. Input items carry a kind
// on s_axis_tuser (symbol, segment start, element start, element end) and a
// text byte on s_axis_tdata. Every item produces exactly one result item with
// a hit flag (set when a symbol completes an occurrence of the pattern) and
// the running occurrence count, which saturates at all ones. Each element of
// a segment starts from the OR of the final states of the previous segment's
// elements. The pattern (up to min(PATTERN_MAX, 32) bytes) and its length are
// written through the cfg port while the block is idle; a length of 0 acts as
// 1 and a length past the bound acts as the bound. Throughput is one item per
// clock unless the skid register is full: the whole state update (parallel
// byte compares, shift, mask, hit select, count increment) sits between the
// state registers and the result register, so each result is registered
// directly. A two-entry output stage (result register plus skid register)
// keeps the input open for one more item while the downstream side stalls.

module eds_shift_and_matcher_top #(
  parameter int unsigned PATTERN_MAX = eds_pkg::PatternMaxDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [eds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [eds_pkg::CfgDataW-1:0] cfg_data_i,

  // input items
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [eds_pkg::InDataW-1:0]  s_axis_tdata,   // [7:0] symbol
  input  logic [eds_pkg::ModeW-1:0]    s_axis_tuser,   // [1:0] mode

  // result items
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [eds_pkg::OutDataW-1:0] m_axis_tdata    // [0] hit, [32:1] match_count, rest 0
);

  // state width follows the usable pattern length
  localparam int unsigned PatW = (PATTERN_MAX < eds_pkg::StateWMax) ? PATTERN_MAX
                                                                    : eds_pkg::StateWMax;
  localparam int unsigned IdxW = (PatW > 1) ? $clog2(PatW) : 1;

  // pattern storage and clamped length (held as index of the last char)
  logic [PatW-1:0][eds_pkg::SymW-1:0] pat_q, pat_d;
  logic [IdxW-1:0]                    last_idx_q, last_idx_d;

  // matcher state
  logic [PatW-1:0]            prefix_q, prefix_d;
  logic [PatW-1:0]            carry_q, carry_d;
  logic [PatW-1:0]            union_q, union_d;
  logic [eds_pkg::CountW-1:0] count_q, count_d;

  // output stage
  logic             out_vld_q, skid_vld_q;
  eds_pkg::result_t out_q, skid_q, res;

  logic             in_acc, out_take;
  eds_pkg::mode_e   mode;
  logic [eds_pkg::SymW-1:0] sym;
  logic [PatW-1:0]  len_mask, char_bits, stepped;
  logic             hit;

  assign mode = eds_pkg::mode_e'(s_axis_tuser);
  assign sym  = s_axis_tdata[eds_pkg::SymW-1:0];

  assign s_axis_tready = ~skid_vld_q;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_take      = out_vld_q & m_axis_tready;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_comb begin
    pat_d      = pat_q;
    last_idx_d = last_idx_q;
    if (cfg_we_i) begin
      // pattern word w covers chars 8w..8w+7; chars past PatW are dropped
      for (int unsigned i = 0; i < PatW; i++) begin
        if (cfg_idx_i == eds_pkg::CfgIdxW'(i / eds_pkg::CharsPerWord)) begin
          pat_d[i] = cfg_data_i[(i % eds_pkg::CharsPerWord) * 8 +: 8];
        end
      end
      if (cfg_idx_i == eds_pkg::CFG_PAT_LEN) begin
        if (cfg_data_i[eds_pkg::LenW-1:0] == '0) begin
          last_idx_d = '0;
        end else if (cfg_data_i[eds_pkg::LenW-1:0] > eds_pkg::LenW'(PatW)) begin
          last_idx_d = IdxW'(PatW - 1);
        end else begin
          last_idx_d = IdxW'(cfg_data_i[eds_pkg::LenW-1:0] - eds_pkg::LenW'(1));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // single-pass state update
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int unsigned i = 0; i < PatW; i++) begin
      len_mask[i]  = (IdxW'(i) <= last_idx_q);
      char_bits[i] = (pat_q[i] == sym) & len_mask[i];
    end
  end

  // shift in a fresh start bit, keep only prefixes that still agree
  assign stepped = ((prefix_q << 1) | PatW'(1)) & char_bits;

  always_comb begin
    prefix_d = prefix_q;
    carry_d  = carry_q;
    union_d  = union_q;
    count_d  = count_q;
    hit      = 1'b0;
    if (in_acc) begin
      case (mode)
        eds_pkg::MODE_SYMBOL: begin
          prefix_d = stepped;
          hit      = stepped[last_idx_q];
          if (hit && (count_q != eds_pkg::CountMax)) begin
            count_d = count_q + eds_pkg::CountW'(1);
          end
        end
        eds_pkg::MODE_SEG_START: begin
          carry_d = union_q;
          union_d = '0;
        end
        eds_pkg::MODE_ELEM_START: begin
          prefix_d = carry_q;
        end
        eds_pkg::MODE_ELEM_END: begin
          union_d = union_q | prefix_q;
        end
        default: begin
          prefix_d = prefix_q;
        end
      endcase
    end
    res.hit         = hit;
    res.match_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idx_q <= '0;
      prefix_q   <= '0;
      carry_q    <= '0;
      union_q    <= '0;
      count_q    <= '0;
      pat_q      <= '0;
    end else begin
      last_idx_q <= last_idx_d;
      prefix_q   <= prefix_d;
      carry_q    <= carry_d;
      union_q    <= union_d;
      count_q    <= count_d;
      pat_q      <= pat_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register with skid entry
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      // skid is empty whenever an item is accepted
      if (in_acc && !(out_vld_q && !m_axis_tready)) begin
        out_vld_q <= 1'b1;
      end else if (out_take) begin
        out_vld_q <= skid_vld_q;
      end
      if (in_acc && out_vld_q && !m_axis_tready) begin
        skid_vld_q <= 1'b1;
      end else if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && skid_vld_q) begin
      out_q <= skid_q;
    end
    if (in_acc) begin
      if (out_vld_q && !m_axis_tready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = eds_pkg::OutDataW'(out_q);

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // skid entry only fills behind a stalled result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid without a pending result");

  // a reported hit always comes with a nonzero count
  a_hit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.hit) |-> (out_q.match_count != '0))
    else $error("hit reported with zero count");

  // after a symbol step no prefix bit survives past the pattern length
  a_prefix_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (mode == eds_pkg::MODE_SYMBOL)) |=> ((prefix_q & ~$past(len_mask)) == '0))
    else $error("prefix bit beyond pattern length");

  // the occurrence count never moves backward
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (count_q >= $past(count_q)))
    else $error("occurrence count decreased");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import eds_pkg::*;

  // longest pattern the state word can follow with the default parameter
  localparam int unsigned LenBound = (PatternMaxDef < StateWMax) ? PatternMaxDef : StateWMax;
  localparam int unsigned PhaseCount = 10;
  localparam int unsigned PhaseItems = 140;
  localparam int unsigned LongHoldCycles = 60;
  localparam int unsigned DirItems = 15;

  // shift-and predictor plus the queue of pending results
  class eds_match_scoreboard;
    logic [CfgDataW-1:0] pat_words [4];
    logic [LenW-1:0]     pat_len;
    logic [31:0]         prefixes;
    logic [31:0]         carry_in;
    logic [31:0]         seg_union;
    logic [CountW-1:0]   occ_count;
    result_t             expected_q [$];
    int unsigned         errors;

    function new();
      foreach (pat_words[i]) pat_words[i] = '0;
      pat_len   = LenW'(1);
      prefixes  = '0;
      carry_in  = '0;
      seg_union = '0;
      occ_count = '0;
      errors    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_PAT_LO:     pat_words[0] = val;
        CFG_PAT_MID_LO: pat_words[1] = val;
        CFG_PAT_MID_HI: pat_words[2] = val;
        CFG_PAT_HI:     pat_words[3] = val;
        CFG_PAT_LEN:    pat_len = val[LenW-1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, anything past the bound acts as the bound
    function int unsigned eff_len();
      int unsigned m;
      m = int'(pat_len);
      if (m < 1) m = 1;
      if (m > LenBound) m = LenBound;
      return m;
    endfunction

    function logic [7:0] pat_char(int unsigned i);
      return pat_words[i / CharsPerWord][(i % CharsPerWord) * 8 +: 8];
    endfunction

    function void note_item(mode_e mode, logic [SymW-1:0] sym);
      int unsigned m;
      logic [31:0] mask;
      result_t     want;
      want.hit = 1'b0;
      case (mode)
        MODE_SYMBOL: begin
          m    = eff_len();
          mask = '0;
          for (int unsigned i = 0; i < m; i++)
            if (pat_char(i) == sym) mask[i] = 1'b1;
          prefixes = ((prefixes << 1) | 32'd1) & mask;
          if (prefixes[m-1]) begin
            want.hit = 1'b1;
            if (occ_count != CountMax) occ_count++;
          end
        end
        MODE_SEG_START: begin
          carry_in  = seg_union;
          seg_union = '0;
        end
        MODE_ELEM_START: prefixes = carry_in;
        default: seg_union |= prefixes;
      endcase
      want.match_count = occ_count;
      expected_q.push_back(want);
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      result_t got;
      result_t want;
      got = result_t'(data[$bits(result_t)-1:0]);
      if (data[OutDataW-1:$bits(result_t)] !== '0) begin
        $error("pad: expected 0, actual %h", data[OutDataW-1:$bits(result_t)]);
        errors++;
      end
      if (expected_q.size() == 0) begin
        $error("result with no item pending: hit=%0d match_count=%0d",
               got.hit, got.match_count);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
        errors++;
      end
      if (got.match_count !== want.match_count) begin
        $error("match_count: expected %0d, actual %0d", want.match_count, got.match_count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_PAT_LO;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // [7:0] symbol
  logic [ModeW-1:0]    s_axis_tuser = MODE_SYMBOL;   // [1:0] mode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;   // [0] hit, [32:1] match_count, rest 0

  eds_match_scoreboard sb;

  // idling controls, changed per phase by the main sequence
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;

  // text generator state: small alphabet plus a cursor walking the pattern
  logic [7:0]  alpha [3];
  int unsigned pat_cursor = 0;

  // directed opening on the reset pattern (one zero byte, length one)
  mode_e dir_modes [DirItems] = '{
    MODE_SYMBOL, MODE_SYMBOL, MODE_ELEM_END, MODE_SEG_START, MODE_ELEM_START,
    MODE_ELEM_END, MODE_SEG_START, MODE_ELEM_START, MODE_SYMBOL, MODE_SYMBOL,
    MODE_ELEM_END, MODE_SEG_START, MODE_ELEM_START, MODE_SYMBOL, MODE_ELEM_END};
  logic [7:0] dir_syms [DirItems] = '{
    8'h00, 8'hFF, 8'h55, 8'hA5, 8'hFF,
    8'h00, 8'h80, 8'h7F, 8'h00, 8'h80,
    8'h01, 8'hFE, 8'h00, 8'h7F, 8'hFF};

  eds_shift_and_matcher_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request counted here
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LongHoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // outputs are stable mid-cycle, so results are checked at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // offer one item, optionally after idle cycles; returns right after the
  // rising edge that accepted it
  task automatic send_item(mode_e mode, logic [7:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tuser  <= mode;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
    end
    @(posedge clk_i);
    sb.note_item(mode, sym);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // new length first so the pattern can be built for its effective size;
  // characters past that size are random and must be ignored
  task automatic load_pattern(logic [CfgDataW-1:0] len_word);
    logic [CfgDataW-1:0] words [4];
    int unsigned m;
    cfg_write(CFG_PAT_LEN, len_word);
    m = sb.eff_len();
    foreach (alpha[i]) alpha[i] = 8'($urandom);
    for (int unsigned w = 0; w < 4; w++)
      for (int unsigned b = 0; b < CharsPerWord; b++)
        words[w][b*8 +: 8] = (w * CharsPerWord + b < m) ? alpha[$urandom_range(2)]
                                                         : 8'($urandom);
    cfg_write(CFG_PAT_LO, words[0]);
    cfg_write(CFG_PAT_MID_LO, words[1]);
    cfg_write(CFG_PAT_MID_HI, words[2]);
    cfg_write(CFG_PAT_HI, words[3]);
    cfg_we_i <= 1'b0;
    pat_cursor = 0;
  endtask

  // mostly walks the pattern so long occurrences show up, sometimes breaks off
  function automatic logic [7:0] next_symbol();
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(99);
    if (r < 65) begin
      c = sb.pat_char(pat_cursor);
      pat_cursor = (pat_cursor + 1) % sb.eff_len();
    end else if (r < 90) begin
      c = alpha[$urandom_range(2)];
      if ($urandom_range(1) == 0) pat_cursor = 0;
    end else begin
      c = 8'($urandom);
    end
    return c;
  endfunction

  // well-formed segments of 1..3 elements with random text, some stray items
  // and some elements missing their start or end marker
  task automatic run_text(int unsigned n_items);
    int unsigned sent;
    int unsigned n_elem;
    int unsigned n_sym;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 6) begin
        send_item(mode_e'($urandom_range(3)), 8'($urandom));
        sent++;
      end else begin
        send_item(MODE_SEG_START, 8'($urandom));
        sent++;
        n_elem = $urandom_range(1, 3);
        for (int unsigned e = 0; e < n_elem; e++) begin
          if ($urandom_range(99) >= 4) begin
            send_item(MODE_ELEM_START, 8'($urandom));
            sent++;
          end
          n_sym = $urandom_range(0, 7);
          for (int unsigned s = 0; s < n_sym; s++) begin
            send_item(MODE_SYMBOL, next_symbol());
            sent++;
          end
          if ($urandom_range(99) >= 4) begin
            send_item(MODE_ELEM_END, 8'($urandom));
            sent++;
          end
        end
      end
    end
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [CfgDataW-1:0] len_word;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset pattern: every item kind, empty element, markers out of order
    for (int unsigned i = 0; i < DirItems; i++) send_item(dir_modes[i], dir_syms[i]);
    s_axis_tvalid <= 1'b0;
    drain();

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      // upper bits of the length word are noise the block must drop
      len_word = {$urandom, $urandom};
      case (p)
        0: len_word[LenW-1:0] = 6'd1;
        1: len_word[LenW-1:0] = 6'd32;
        2: len_word[LenW-1:0] = 6'd0;                 // acts as one
        3: len_word[LenW-1:0] = 6'd63;                // clamps to the bound
        4: len_word[LenW-1:0] = 6'($urandom_range(33, 62));
        default: len_word[LenW-1:0] = ($urandom_range(3) == 0) ?
                   6'($urandom_range(11, 32)) : 6'($urandom_range(2, 10));
      endcase
      // state carries over, so a new length also hits a live prefix state
      load_pattern(len_word);

      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      // full-rate sender against a parked receiver: output fills, input stalls
      if (p == 4 || p == 8) hold_request = 1'b1;

      run_text(PhaseItems);
      s_axis_tvalid <= 1'b0;
      drain();
    end

    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
